// ===== hdl/bps_pkg.sv =====
// shared types and constants for the byte pattern search unit
package bps_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned PAT_WORD_W = 64;
  localparam int unsigned PAT_SLOTS  = 16;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned OUT_POS_W  = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2,
    REG_UNUSED         = 2'd3
  } cfg_reg_t;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== hdl/bps_in_if.sv =====
// input channel: stream bytes with end marker
interface bps_in_if;
  import bps_pkg::*;
  logic  valid;
  logic  ready;
  byte_t stream_byte;
  logic  end_of_stream;
  modport source (output valid, stream_byte, end_of_stream, input ready);
  modport sink   (input valid, stream_byte, end_of_stream, output ready);
endinterface

// ===== hdl/bps_out_if.sv =====
// result channel: found flag and match position
interface bps_out_if;
  import bps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [OUT_POS_W-1:0] match_position;
  modport source (output valid, found, match_position, input ready);
  modport sink   (input valid, found, match_position, output ready);
endinterface

// ===== hdl/bps_cfg_if.sv =====
// configuration write channel
interface bps_cfg_if;
  import bps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [PAT_WORD_W-1:0] wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== hdl/byte_pattern_search_unit.sv =====
// top level: byte pattern search over a chain of window cells
//
//   channel  dir  carries
//   in_bus   in   stream_byte, end_of_stream
//   out_bus  out  found, match_position
//   cfg_bus  in   reg_index, wr_data (length, pattern low, pattern high)
//
// one byte is taken every cycle; a result word that a byte produces appears in the
// output register on the next cycle. the compare of all cells and the position
// subtract sit in the single stage in front of that register.
// input stalls only while a result word is held and out_bus.ready is low.
// reset clears the window, byte count, match flag and all three registers.
// configuration writes are taken in any cycle.
module byte_pattern_search_unit #(
  parameter int unsigned MAX_PATTERN   = 16,
  parameter int unsigned POSITION_BITS = 32
) (
  input logic       clk,
  input logic       rst_n,
  bps_in_if.sink    in_bus,
  bps_out_if.source out_bus,
  bps_cfg_if.sink   cfg_bus
);
  import bps_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

  // configuration registers
  logic [LEN_W-1:0]      pat_len_r;
  logic [PAT_WORD_W-1:0] pat_lo_r;
  logic [PAT_WORD_W-1:0] pat_hi_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r <= '0;
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
    end else if (cfg_bus.valid) begin
      unique case (cfg_reg_t'(cfg_bus.reg_index))
        REG_PATTERN_LENGTH: pat_len_r <= cfg_bus.wr_data[LEN_W-1:0];
        REG_PATTERN_LOW:    pat_lo_r  <= cfg_bus.wr_data;
        REG_PATTERN_HIGH:   pat_hi_r  <= cfg_bus.wr_data;
        default: ;
      endcase
    end
  end

  byte_t pat_bytes [PAT_SLOTS];
  always_comb begin
    for (int i = 0; i < PAT_SLOTS / 2; i++) begin
      pat_bytes[i]                 = pat_lo_r[i*BYTE_W +: BYTE_W];
      pat_bytes[i + PAT_SLOTS / 2] = pat_hi_r[i*BYTE_W +: BYTE_W];
    end
  end

  // handshake
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 found_r;
  logic [OUT_POS_W-1:0] pos_r;
  logic                 in_ready;
  logic                 acc;

  assign in_ready     = !out_valid_r || out_bus.ready;
  assign in_bus.ready = in_ready;
  assign acc          = in_bus.valid && in_ready;

  // stream state
  logic [POSITION_BITS-1:0] seen_r;
  logic [POSITION_BITS-1:0] seen_inc;
  logic [POSITION_BITS-1:0] seen_nxt;
  logic                     reported_r;
  logic                     reported_nxt;
  logic                     last;

  assign last     = in_bus.end_of_stream;
  assign seen_inc = (seen_r == '1) ? seen_r : seen_r + POSITION_BITS'(1);

  // chain of cells
  cell_ctrl_t ctrl;
  byte_t      cell_in  [MAX_PATTERN];
  byte_t      cell_out [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hit;
  logic [MAX_PATTERN-1:0] cell_ok;

  assign ctrl.shift = acc;
  assign ctrl.clear = acc && last;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [LEN_W-1:0] pidx;
    if (k == 0) begin : g_head
      assign cell_in[k] = in_bus.stream_byte;
    end else begin : g_link
      assign cell_in[k] = cell_out[k-1];
    end
    // cell k lines up with pattern byte len-1-k
    assign pidx = pat_len_r - LEN_W'(1) - LEN_W'(k);

    bps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .byte_in  (cell_in[k]),
      .pat_byte (pat_bytes[pidx[SLOT_W-1:0]]),
      .byte_out (cell_out[k]),
      .hit      (hit[k])
    );
    assign cell_ok[k] = (LEN_W'(k) >= pat_len_r) || hit[k];
  end

  logic [POSITION_BITS-1:0] len_ext;
  logic [POSITION_BITS-1:0] pos_full;
  logic [OUT_POS_W-1:0]     pos_clip;
  logic                     match_now;
  logic                     emit;

  assign len_ext   = {{(POSITION_BITS-LEN_W){1'b0}}, pat_len_r};
  assign pos_full  = seen_inc - len_ext;
  assign match_now = !reported_r && (pat_len_r != '0) && (pat_len_r <= MAX_LEN) &&
                     (seen_inc >= len_ext) && (&cell_ok);
  assign emit      = acc && (match_now || (last && !reported_r));

  if (POSITION_BITS > OUT_POS_W) begin : g_clip
    assign pos_clip = (|pos_full[POSITION_BITS-1:OUT_POS_W]) ? '1
                                                              : pos_full[OUT_POS_W-1:0];
  end else begin : g_wide
    assign pos_clip = OUT_POS_W'(pos_full);
  end

  always_comb begin
    seen_nxt     = seen_r;
    reported_nxt = reported_r;
    if (acc) begin
      if (last) begin
        seen_nxt     = '0;
        reported_nxt = 1'b0;
      end else begin
        seen_nxt     = seen_inc;
        reported_nxt = reported_r || match_now;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      reported_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seen_r      <= seen_nxt;
      reported_r  <= reported_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (emit) begin
      found_r <= match_now;
      pos_r   <= match_now ? pos_clip : '0;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.found          = found_r;
  assign out_bus.match_position = pos_r;

  // a not-found word always carries position zero
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !found_r |-> pos_r == '0)
    else $error("not-found word with nonzero position");

  // end of stream leaves a fresh stream behind
  a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    acc && last |=> seen_r == '0 && !reported_r)
    else $error("stream state not cleared after end of stream");

  // a match mid-stream blocks further matches
  a_match_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    acc && match_now && !last |=> reported_r)
    else $error("match flag not set after a match");

  // a new result word only follows an accepted byte
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(acc))
    else $error("result word without an accepted byte");

endmodule

// ===== hdl/bps_cell.sv =====
// one window cell: holds one stream byte and compares the byte it takes in
module bps_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  bps_pkg::cell_ctrl_t ctrl,
  input  bps_pkg::byte_t     byte_in,
  input  bps_pkg::byte_t     pat_byte,
  output bps_pkg::byte_t     byte_out,
  output logic               hit
);
  import bps_pkg::*;

  byte_t byte_r;
  byte_t byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctrl.clear) begin
      byte_nxt = '0;
    end else if (ctrl.shift) begin
      byte_nxt = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  // compare against the byte this cell holds after the shift
  assign hit      = (byte_in == pat_byte);
  assign byte_out = byte_r;

endmodule
